>>> hdl/assert_macros.svh
// assertion macros shared by the limiter rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/ampl_pkg.sv
// constants and register codes for the audio mix peak limiter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ampl_pkg;

  localparam int GAIN_FRAC  = 23;  // limiter gain and threshold, Q1.23
  localparam int MIX_FRAC   = 14;  // wet gain Q2.14, dry gain Q1.14
  localparam int GAIN_W     = 24;
  localparam int WET_W      = 16;
  localparam int DRY_W      = 15;
  localparam int CFG_W      = 24;
  localparam int CFG_IDX_W  = 3;

  localparam int MIX_STEPS  = WET_W;
  localparam int DIV_STEPS  = GAIN_FRAC;
  localparam int MUL_STEPS  = GAIN_W;
  localparam int MIX_CNT_W  = $clog2(MIX_STEPS);
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);

  localparam logic [GAIN_W-1:0] GAIN_ONE = 24'h800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECEIVE_MODE    = 3'd0,
    REG_LIMITER_ENABLE  = 3'd1,
    REG_LIMIT_THRESHOLD = 3'd2,
    REG_RELEASE_STEP    = 3'd3,
    REG_DRY_GAIN        = 3'd4,
    REG_WET_GAIN        = 3'd5
  } cfg_reg_t;

  // start and finish handshake between the sequencer and a serial unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
  } unit_rsp_t;

endpackage

>>> hdl/audio_mix_peak_limiter.sv
// audio mix and peak limiter, one word in and one word out per sample
// from accept to out_valid the path is shortest in transmit with the limiter off; the gain
// multiply lengthens it, and the receive mix and the attack division lengthen it further
// one sample in flight: the next word is taken the cycle after the result registers,
// so a new word waits for the one before it and for any output stall; an output register holds the word
// sync reset: registers to their defaults, limiter gain to unity, channels empty
`timescale 1ns / 1ps

module audio_mix_peak_limiter
  import ampl_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] local_sample,
  input  logic [SAMPLE_BITS-1:0] return_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_sample,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  `include "assert_macros.svh"

  localparam int SB = SAMPLE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MIX, ST_LIMIT, ST_DIV, ST_MULGO, ST_MUL, ST_FINISH
  } state_t;

  state_t state;

  logic              receive_mode;
  logic              limiter_enable;
  logic [CFG_W-1:0]  limit_threshold;
  logic [CFG_W-1:0]  release_step;
  logic [DRY_W-1:0]  dry_gain;
  logic [WET_W-1:0]  wet_gain;
  logic [GAIN_W-1:0] limiter_gain;

  logic [SB-1:0]     loc;
  logic [SB-1:0]     ret;
  logic [SB+1:0]     mix_sample;
  logic [SB+3:0]     lim_sample;

  unit_req_t mix_req, div_req, mul_req;
  unit_rsp_t mix_rsp, div_rsp, mul_rsp;

  logic [SB+1:0]        mix_out;
  logic [GAIN_FRAC-1:0] div_quot;
  logic [SB+3:0]        mul_prod;

  logic [SB-1:0]     thr;
  logic [SB+1:0]     mag;
  logic              attack;
  logic [GAIN_W:0]   rel_sum;
  logic [GAIN_W-1:0] rel_gain;
  logic [SB-1:0]     out_sat;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      receive_mode    <= 1'b0;
      limiter_enable  <= 1'b1;
      limit_threshold <= 24'd7549747;
      release_step    <= 24'd1748;
      dry_gain        <= '0;
      wet_gain        <= 16'd16384;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RECEIVE_MODE:    receive_mode    <= cfg_data[0];
        REG_LIMITER_ENABLE:  limiter_enable  <= cfg_data[0];
        REG_LIMIT_THRESHOLD: limit_threshold <= cfg_data;
        REG_RELEASE_STEP:    release_step    <= cfg_data;
        REG_DRY_GAIN:        dry_gain        <= cfg_data[DRY_W-1:0];
        REG_WET_GAIN:        wet_gain        <= cfg_data[WET_W-1:0];
        default: ;
      endcase
    end
  end

  // threshold brought to the sample scale
  if (SB > CFG_W) begin : g_thr_up
    assign thr = {limit_threshold, {(SB-CFG_W){1'b0}}};
  end else if (SB == CFG_W) begin : g_thr_eq
    assign thr = limit_threshold;
  end else begin : g_thr_dn
    assign thr = limit_threshold[CFG_W-1:CFG_W-SB];
  end

  always_comb begin
    mag      = mix_sample[SB+1] ? (~mix_sample + 1'b1) : mix_sample;
    attack   = (mag > {2'b00, thr});
    rel_sum  = {1'b0, limiter_gain} + {1'b0, release_step};
    rel_gain = (rel_sum > {1'b0, GAIN_ONE}) ? GAIN_ONE : rel_sum[GAIN_W-1:0];
    if (lim_sample[SB+3:SB-1] != {5{lim_sample[SB+3]}}) begin
      out_sat = lim_sample[SB+3] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end else begin
      out_sat = lim_sample[SB-1:0];
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      limiter_gain  <= GAIN_ONE;
      mix_req.start <= 1'b0;
      div_req.start <= 1'b0;
      mul_req.start <= 1'b0;
    end else begin
      mix_req.start <= (state == ST_IDLE) && in_valid && receive_mode;
      div_req.start <= (state == ST_LIMIT) && limiter_enable && attack;
      mul_req.start <= (state == ST_MULGO);
      if ((state == ST_FINISH) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            loc <= local_sample;
            ret <= return_sample;
            if (receive_mode) begin
              state <= ST_MIX;
            end else begin
              mix_sample <= {{2{local_sample[SB-1]}}, local_sample};
              state      <= ST_LIMIT;
            end
          end
        end
        ST_MIX: begin
          if (mix_rsp.done) begin
            mix_sample <= mix_out;
            state      <= ST_LIMIT;
          end
        end
        ST_LIMIT: begin
          if (!limiter_enable) begin
            lim_sample <= {{2{mix_sample[SB+1]}}, mix_sample};
            state      <= ST_FINISH;
          end else if (attack) begin
            state <= ST_DIV;
          end else begin
            limiter_gain <= rel_gain;
            state        <= ST_MULGO;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            limiter_gain <= {1'b0, div_quot};
            state        <= ST_MULGO;
          end
        end
        ST_MULGO: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_rsp.done) begin
            lim_sample <= mul_prod;
            state      <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_sample <= out_sat;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ampl_mix #(.SB(SB)) u_mix (
    .clk  (clk),
    .rst  (rst),
    .req  (mix_req),
    .rsp  (mix_rsp),
    .loc  (loc),
    .ret  (ret),
    .wet  (wet_gain),
    .dry  (dry_gain),
    .mix  (mix_out)
  );

  ampl_div #(.SB(SB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .rsp      (div_rsp),
    .dividend (thr),
    .divisor  (mag),
    .quot     (div_quot)
  );

  ampl_mul #(.SB(SB)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .rsp  (mul_rsp),
    .mix  (mix_sample),
    .gain (limiter_gain),
    .prod (mul_prod)
  );

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `ASSERT_IMPLIES(a_gain_le_unity, clk, rst, 1'b1, limiter_gain <= GAIN_ONE)
  `ASSERT_NEXT(a_gain_held_when_off, clk, rst, state == ST_LIMIT && !limiter_enable, $stable(limiter_gain))

endmodule

>>> hdl/ampl_mix.sv
// bit-serial dry/wet mixer: one gain bit per cycle, msb first, then rounding
// depends on ampl_pkg
`timescale 1ns / 1ps

module ampl_mix
  import ampl_pkg::*;
#(
  parameter int SB = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  unit_req_t            req,
  output unit_rsp_t            rsp,
  input  logic [SB-1:0]        loc,
  input  logic [SB-1:0]        ret,
  input  logic [WET_W-1:0]     wet,
  input  logic [DRY_W-1:0]     dry,
  output logic signed [SB+1:0] mix
);

  localparam int AW = SB + 18;
  localparam logic [AW-1:0] HALF =
    {{(AW-MIX_FRAC){1'b0}}, 1'b1, {(MIX_FRAC-1){1'b0}}};

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_ROUND} mstate_t;

  mstate_t              state;
  logic [MIX_CNT_W-1:0] cnt;
  logic [WET_W-1:0]     wsh;
  logic [WET_W-1:0]     dsh;
  logic [AW-1:0]        acc;
  logic [AW-1:0]        acc_next;
  logic [AW-1:0]        rnd_sum;
  logic [SB+3:0]        v;
  logic [SB+1:0]        v_sat;

  always_comb begin
    acc_next = {acc[AW-2:0], 1'b0};
    if (wsh[WET_W-1]) begin
      acc_next = acc_next + {{(AW-SB){ret[SB-1]}}, ret};
    end
    if (dsh[WET_W-1]) begin
      acc_next = acc_next + {{(AW-SB){loc[SB-1]}}, loc};
    end
  end

  // round half up, floor shift, then clamp to sb+2 bits
  always_comb begin
    rnd_sum = acc + HALF;
    v       = rnd_sum[AW-1:MIX_FRAC];
    if (v[SB+3:SB+1] != {3{v[SB+3]}}) begin
      v_sat = v[SB+3] ? {1'b1, {(SB+1){1'b0}}} : {1'b0, {(SB+1){1'b1}}};
    end else begin
      v_sat = v[SB+1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= (state == S_ROUND);
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            wsh   <= wet;
            dsh   <= {1'b0, dry};
            acc   <= '0;
            cnt   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          acc <= acc_next;
          wsh <= {wsh[WET_W-2:0], 1'b0};
          dsh <= {dsh[WET_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == MIX_CNT_W'(MIX_STEPS - 1)) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          mix   <= v_sat;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/ampl_div.sv
// restoring divider for the attack gain: threshold * 2^23 / magnitude,
// one quotient bit per cycle; depends on ampl_pkg
`timescale 1ns / 1ps

module ampl_div
  import ampl_pkg::*;
#(
  parameter int SB = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  unit_req_t            req,
  output unit_rsp_t            rsp,
  input  logic [SB-1:0]        dividend,
  input  logic [SB+1:0]        divisor,
  output logic [GAIN_FRAC-1:0] quot
);

  localparam int RW = SB + 3;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [RW-1:0]        rem;
  logic [RW-1:0]        sh;
  logic [RW-1:0]        dvs;
  logic                 qbit;

  // dividend is below divisor, so the quotient fits 23 bits
  always_comb begin
    sh   = {rem[RW-2:0], 1'b0};
    dvs  = {1'b0, divisor};
    qbit = (sh >= dvs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= !req.start && busy && (cnt == DIV_CNT_W'(DIV_STEPS - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= {3'b000, dividend};
        quot <= '0;
      end else if (busy) begin
        rem  <= qbit ? (sh - dvs) : sh;
        quot <= {quot[GAIN_FRAC-2:0], qbit};
        cnt  <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> hdl/ampl_mul.sv
// bit-serial gain multiplier: one limiter gain bit per cycle, msb first,
// then round half up at 2^-23; depends on ampl_pkg
`timescale 1ns / 1ps

module ampl_mul
  import ampl_pkg::*;
#(
  parameter int SB = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  unit_req_t            req,
  output unit_rsp_t            rsp,
  input  logic [SB+1:0]        mix,
  input  logic [GAIN_W-1:0]    gain,
  output logic [SB+3:0]        prod
);

  localparam int PW = SB + 27;
  localparam logic [PW-1:0] HALF =
    {{(PW-GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}};

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_ROUND} ustate_t;

  ustate_t              state;
  logic [MUL_CNT_W-1:0] cnt;
  logic [GAIN_W-1:0]    gsh;
  logic [PW-1:0]        acc;
  logic [PW-1:0]        acc_next;
  logic [PW-1:0]        rnd_sum;

  always_comb begin
    acc_next = {acc[PW-2:0], 1'b0};
    if (gsh[GAIN_W-1]) begin
      acc_next = acc_next + {{(PW-SB-2){mix[SB+1]}}, mix};
    end
    rnd_sum = acc + HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= (state == S_ROUND);
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            gsh   <= gain;
            acc   <= '0;
            cnt   <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          acc <= acc_next;
          gsh <= {gsh[GAIN_W-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          prod  <= rnd_sum[PW-1:GAIN_FRAC];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> dv/audio_mix_peak_limiter_test.sv
// self-checking testbench for the audio mix and peak limiter
// depends on ampl_pkg and audio_mix_peak_limiter; directed table, then random phases
`timescale 1ns / 1ps

module audio_mix_peak_limiter_test;
  import ampl_pkg::*;

  localparam int SAMPLE_BITS = 24;
  localparam int RAND_PHASES = 9;
  localparam int PHASE_WORDS = 181;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES = 100;
  localparam longint GAIN_UNITY = longint'(GAIN_ONE);
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum bit {ROW_REG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      data;
    sample_t               loc;
    sample_t               ret;
    bit                    known;
    sample_t               expv;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  sample_t              local_sample = '0;
  sample_t              return_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sample_t              out_sample;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // predictor copy of the registers and the limiter gain
  longint cfg_receive, cfg_limit_on, cfg_threshold, cfg_release, cfg_dry, cfg_wet;
  longint gain_state;

  sample_t  pending_out[$];
  dir_row_t directed[$];
  sample_t  oldest_out;
  int       errors = 0;
  int       idle_cycles = 0;
  int       send_gap_pct = 0;
  int       recv_stall_pct = 0;

  audio_mix_peak_limiter #(.SAMPLE_BITS(SAMPLE_BITS)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .local_sample  (local_sample),
    .return_sample (return_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // mix, limit and saturate one sample; advances the limiter gain
  function automatic sample_t limited_sample(input sample_t loc_w, input sample_t ret_w);
    longint loc, ret, mix, mag, y;
    loc = longint'($signed(loc_w));
    ret = longint'($signed(ret_w));
    if (cfg_receive != 0)
      mix = clamp(round_shift(cfg_wet * ret + cfg_dry * loc, MIX_FRAC), SAMPLE_BITS + 2);
    else
      mix = loc;
    if (cfg_limit_on != 0) begin
      mag = (mix < 0) ? -mix : mix;
      if (mag > cfg_threshold) begin
        gain_state = (cfg_threshold <<< GAIN_FRAC) / mag;
      end else begin
        gain_state = gain_state + cfg_release;
        if (gain_state > GAIN_UNITY) gain_state = GAIN_UNITY;
      end
      y = round_shift(mix * gain_state, GAIN_FRAC);
    end else begin
      y = mix;
    end
    y = clamp(y, SAMPLE_BITS);
    return y[SAMPLE_BITS-1:0];
  endfunction

  function automatic sample_t rand_sample();
    int m;
    case ($urandom_range(9))
      0, 1, 2, 3: rand_sample = sample_t'($urandom);
      4, 5, 6:    rand_sample = sample_t'($urandom_range(131072) - 65536);
      default: begin
        // loud words to push the limiter into attack
        m = int'($urandom_range(8388607, 6000000));
        rand_sample = sample_t'($urandom_range(1) ? m : -m);
      end
    endcase
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
    dir_row_t r;
    r = '{ROW_REG, idx, data, '0, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic dir_row_t word_row(input sample_t loc, input sample_t ret,
                                        input bit known, input sample_t expv);
    dir_row_t r;
    r = '{ROW_WORD, '0, '0, loc, ret, known, expv};
    return r;
  endfunction

  function automatic void add_row(input dir_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    // write enable is lowered by the next word sent
    case (idx)
      REG_RECEIVE_MODE:    cfg_receive   = longint'(data[0]);
      REG_LIMITER_ENABLE:  cfg_limit_on  = longint'(data[0]);
      REG_LIMIT_THRESHOLD: cfg_threshold = longint'(data[23:0]);
      REG_RELEASE_STEP:    cfg_release   = longint'(data[23:0]);
      REG_DRY_GAIN:        cfg_dry       = longint'(data[DRY_W-1:0]);
      REG_WET_GAIN:        cfg_wet       = longint'(data[WET_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic send_word(input sample_t loc, input sample_t ret,
                           input bit known, input sample_t expv);
    sample_t predicted;
    cfg_we <= 1'b0;
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    in_valid      <= 1'b1;
    local_sample  <= loc;
    return_sample <= ret;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = limited_sample(loc, ret);
    pending_out.insert(pending_out.size(), known ? expv : predicted);
  endtask

  // output side: stall, check, watchdog
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_out.size() == 0) begin
          $display("%0t unexpected word: expected none actual %0d", $time,
                   $signed(out_sample));
          errors++;
        end else begin
          oldest_out = pending_out.pop_front();
          if (oldest_out !== out_sample) begin
            $display("%0t out_sample mismatch: expected %0d actual %0d", $time,
                     $signed(oldest_out), $signed(out_sample));
            errors++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] thr_v, rel_v, dry_v, wet_v;

    cfg_receive   = 0;
    cfg_limit_on  = 1;
    cfg_threshold = 7549747;
    cfg_release   = 1748;
    cfg_dry       = 0;
    cfg_wet       = 16384;
    gain_state    = GAIN_UNITY;

    // defaults after reset: transmit, limiter on
    add_row(word_row(0, 0, 1'b1, 0));
    add_row(word_row(100, 24'h7fffff, 1'b1, 100));
    add_row(word_row(-24'sd100, 24'h800000, 1'b1, -24'sd100));
    add_row(word_row(24'h7fffff, 0, 1'b0, 0));
    add_row(word_row(24'h800000, 0, 1'b0, 0));
    add_row(word_row(1000, 0, 1'b0, 0));
    // limiter off passes the word through
    add_row(reg_row(REG_LIMITER_ENABLE, 0));
    add_row(word_row(24'h7fffff, 0, 1'b1, 24'h7fffff));
    add_row(word_row(24'h800000, 0, 1'b1, 24'h800000));
    // receive mix at unity gains, saturating at both ends
    add_row(reg_row(REG_RECEIVE_MODE, 1));
    add_row(reg_row(REG_DRY_GAIN, 16384));
    add_row(word_row(24'h7fffff, 24'h7fffff, 1'b1, 24'h7fffff));
    add_row(word_row(24'h800000, 24'h800000, 1'b1, 24'h800000));
    add_row(word_row(1000, 2000, 1'b1, 3000));
    // gains written beyond their width are masked
    add_row(reg_row(REG_DRY_GAIN, 24'hffffff));
    add_row(reg_row(REG_WET_GAIN, 24'hffffff));
    add_row(word_row(24'h123456, 24'hfedcba, 1'b0, 0));
    add_row(word_row(-24'sd3, 5, 1'b0, 0));
    add_row(reg_row(REG_DRY_GAIN, 0));
    add_row(reg_row(REG_WET_GAIN, 0));
    add_row(word_row(5000, 7000, 1'b1, 0));
    // writes to unused indexes are ignored
    add_row(reg_row(IDX_SPARE_LO, 24'h00ffff));
    add_row(reg_row(IDX_SPARE_HI, 24'hffffff));
    add_row(word_row(5000, 7000, 1'b1, 0));
    // zero threshold: any nonzero word drops the gain to zero
    add_row(reg_row(REG_LIMITER_ENABLE, 1));
    add_row(reg_row(REG_WET_GAIN, 16384));
    add_row(reg_row(REG_LIMIT_THRESHOLD, 0));
    add_row(word_row(0, 1, 1'b1, 0));
    add_row(word_row(0, 0, 1'b1, 0));
    add_row(word_row(0, 24'h7fffff, 1'b0, 0));
    // threshold at and above full scale
    add_row(reg_row(REG_LIMIT_THRESHOLD, 24'h800000));
    add_row(word_row(0, 24'h800000, 1'b0, 0));
    add_row(reg_row(REG_LIMIT_THRESHOLD, 24'hffffff));
    add_row(word_row(0, 24'h7fffff, 1'b0, 0));
    // huge release step snaps back to unity
    add_row(reg_row(REG_LIMIT_THRESHOLD, 4194304));
    add_row(reg_row(REG_RELEASE_STEP, 24'hffffff));
    add_row(word_row(0, 24'h7fffff, 1'b0, 0));
    add_row(word_row(0, 100, 1'b1, 100));
    // no release: gain holds after an attack
    add_row(reg_row(REG_RELEASE_STEP, 0));
    add_row(reg_row(REG_WET_GAIN, 32768));
    add_row(word_row(0, 24'h7fffff, 1'b0, 0));
    add_row(word_row(0, 1000, 1'b0, 0));
    add_row(word_row(24'h400000, 24'hc00000, 1'b0, 0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct   = 14;
    recv_stall_pct = 74;
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REG)
        write_reg(directed[i].idx, directed[i].data);
      else
        send_word(directed[i].loc, directed[i].ret, directed[i].known, directed[i].expv);
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase / 3)
        0: begin
          send_gap_pct   = 14;
          recv_stall_pct = 74;
        end
        1: begin
          send_gap_pct   = 74;
          recv_stall_pct = 14;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase

      case ($urandom_range(7))
        0:       thr_v = 0;
        1:       thr_v = 24'h800000;
        2:       thr_v = 24'hffffff;
        default: thr_v = CFG_W'($urandom_range(8388608, 1048576));
      endcase
      case ($urandom_range(5))
        0:       rel_v = 0;
        1:       rel_v = 24'h800000;
        2:       rel_v = CFG_W'($urandom);
        default: rel_v = CFG_W'($urandom_range(20000));
      endcase
      case ($urandom_range(4))
        0:       dry_v = 0;
        1:       dry_v = 16384;
        2:       dry_v = CFG_W'($urandom);
        default: dry_v = CFG_W'($urandom_range(16384));
      endcase
      case ($urandom_range(4))
        0:       wet_v = 0;
        1:       wet_v = 32768;
        2:       wet_v = CFG_W'($urandom);
        default: wet_v = CFG_W'($urandom_range(32768));
      endcase
      write_reg(REG_RECEIVE_MODE, CFG_W'((phase % 3) != 0));
      write_reg(REG_LIMITER_ENABLE, CFG_W'((phase % 4) != 3));
      write_reg(REG_LIMIT_THRESHOLD, thr_v);
      write_reg(REG_RELEASE_STEP, rel_v);
      write_reg(REG_DRY_GAIN, dry_v);
      write_reg(REG_WET_GAIN, wet_v);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (phase == 1 && n == PHASE_WORDS / 2) drain_results();
        // return path is empty now and then
        send_word(rand_sample(), ($urandom_range(9) == 0) ? '0 : rand_sample(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_out.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
